@@ rtl/hsvca_pkg.sv @@
// Shared constants, types and arithmetic helpers for the HSV color adjust pipeline.
package hsvca_pkg;

    localparam int CB       = 8;
    localparam int CMAX     = (1 << CB) - 1;
    localparam int HUE_SEXT = 256;
    localparam int HUE_TURN = 6 * HUE_SEXT;
    localparam int HW       = 11;
    localparam int QW       = (CB > 9) ? CB : 9;
    localparam int NW       = CB + QW;
    localparam int DY       = 2 * CB + 1;
    localparam int BY       = CB + 9;
    localparam int XW       = 2 * CB + 9;
    localparam int WMAX     = 255;
    localparam int FULL     = CMAX * HUE_SEXT;
    localparam int CFG_W    = 12;
    localparam int CFG_IW   = 2;

    localparam int DK = DY + 1;
    localparam longint unsigned DRC = (64'd1 << DK) / CMAX;
    localparam int BK = BY + 1;
    localparam longint unsigned BRC = (64'd1 << BK) / WMAX;

    typedef enum logic [1:0] {
        MAX_RED   = 2'b00,
        MAX_GREEN = 2'b01,
        MAX_BLUE  = 2'b10
    } t_maxc;

    typedef enum logic [CFG_IW-1:0] {
        CFG_HUE = 2'd0,
        CFG_SAT = 2'd1,
        CFG_VAL = 2'd2,
        CFG_SEL = 2'd3
    } t_cfg;

    typedef struct packed {
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        logic [7:0]    w;
        logic [CB-1:0] v;
        t_maxc         mc;
        logic          neg;
        logic          wrap;
        logic          dz;
    } t_side;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [CB-1:0] den;
        logic [QW-1:0] quo;
    } t_dl;

    typedef struct packed {
        logic signed [11:0] hue;
        logic signed [8:0]  sat;
        logic signed [8:0]  val;
    } t_adj;

    function automatic t_dl div_step(t_dl x, int bitpos);
        t_dl           o;
        logic [NW-1:0] sh;
        o  = x;
        sh = NW'(x.den) << bitpos;
        if (x.rem >= sh) begin
            o.rem         = x.rem - sh;
            o.quo[bitpos] = 1'b1;
        end
        return o;
    endfunction

    function automatic logic [CB-1:0] div_cmax(logic [DY-1:0] y);
        logic [63:0] prod;
        logic [63:0] q0;
        logic [63:0] rem;
        prod = 64'(y) * DRC;
        q0   = prod >> DK;
        rem  = 64'(y) - q0 * 64'(CMAX);
        if (rem >= 64'(CMAX)) begin
            q0 = q0 + 64'd1;
        end
        return CB'(q0);
    endfunction

    function automatic logic [CB-1:0] div_w(logic [BY-1:0] y);
        logic [63:0] prod;
        logic [63:0] q0;
        logic [63:0] rem;
        prod = 64'(y) * BRC;
        q0   = prod >> BK;
        rem  = 64'(y) - q0 * 64'(WMAX);
        if (rem >= 64'(WMAX)) begin
            q0 = q0 + 64'd1;
        end
        return CB'(q0);
    endfunction

endpackage

@@ rtl/hsvca_front.sv @@
// Input register, max/min analysis and divider operand setup.
module hsvca_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [hsvca_pkg::CB-1:0] i_red,
    input  logic [hsvca_pkg::CB-1:0] i_green,
    input  logic [hsvca_pkg::CB-1:0] i_blue,
    input  logic [7:0]              i_weight,
    input  logic                    i_sel,
    output logic                    o_valid,
    output hsvca_pkg::t_side        o_side,
    output hsvca_pkg::t_dl          o_ls,
    output hsvca_pkg::t_dl          o_lh
);

    logic                     r_v1;
    logic [hsvca_pkg::CB-1:0] r_r, r_g, r_b;
    logic [7:0]               r_w;
    logic                     r_v2;
    hsvca_pkg::t_side         r_sd;
    hsvca_pkg::t_dl           r_ls, r_lh;

    logic [hsvca_pkg::CB-1:0] mx, mn, delta, mag;
    logic signed [hsvca_pkg::CB:0] diff;
    hsvca_pkg::t_maxc         mc;
    hsvca_pkg::t_side         n_sd;
    hsvca_pkg::t_dl           n_ls, n_lh;

    always_comb begin
        mx = r_r;
        mn = r_r;
        if (r_g > mx) mx = r_g;
        if (r_b > mx) mx = r_b;
        if (r_g < mn) mn = r_g;
        if (r_b < mn) mn = r_b;
        delta = mx - mn;
        if (mx == r_r) begin
            mc   = hsvca_pkg::MAX_RED;
            diff = $signed({1'b0, r_g}) - $signed({1'b0, r_b});
        end else if (mx == r_g) begin
            mc   = hsvca_pkg::MAX_GREEN;
            diff = $signed({1'b0, r_b}) - $signed({1'b0, r_r});
        end else begin
            mc   = hsvca_pkg::MAX_BLUE;
            diff = $signed({1'b0, r_r}) - $signed({1'b0, r_g});
        end
        mag = (diff < 0) ? hsvca_pkg::CB'(-diff) : hsvca_pkg::CB'(diff);

        n_sd.r    = r_r;
        n_sd.g    = r_g;
        n_sd.b    = r_b;
        n_sd.w    = r_w;
        n_sd.v    = mx;
        n_sd.mc   = mc;
        n_sd.neg  = diff < 0;
        n_sd.wrap = (mc == hsvca_pkg::MAX_RED) && (r_g < r_b);
        n_sd.dz   = delta == '0;

        n_ls.rem = hsvca_pkg::NW'(delta) * hsvca_pkg::NW'(hsvca_pkg::CMAX)
                 + hsvca_pkg::NW'(mx >> 1);
        n_ls.den = mx;
        n_ls.quo = '0;
        n_lh.rem = (hsvca_pkg::NW'(mag) << 8) + hsvca_pkg::NW'(delta >> 1);
        n_lh.den = delta;
        n_lh.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r  <= i_red;
            r_g  <= i_green;
            r_b  <= i_blue;
            r_w  <= i_sel ? i_weight : 8'(hsvca_pkg::WMAX);
            r_sd <= n_sd;
            r_ls <= n_ls;
            r_lh <= n_lh;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_sd;
    assign o_ls    = r_ls;
    assign o_lh    = r_lh;

endmodule

@@ rtl/hsvca_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for saturation and hue.
module hsvca_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  hsvca_pkg::t_side         i_side,
    input  hsvca_pkg::t_dl           i_ls,
    input  hsvca_pkg::t_dl           i_lh,
    output logic                     o_valid,
    output hsvca_pkg::t_side         o_side,
    output logic [hsvca_pkg::CB-1:0] o_qs,
    output logic [8:0]               o_qh
);

    logic [hsvca_pkg::QW-1:0] r_vld;
    hsvca_pkg::t_side         r_sd [hsvca_pkg::QW];
    hsvca_pkg::t_dl           r_ls [hsvca_pkg::QW];
    hsvca_pkg::t_dl           r_lh [hsvca_pkg::QW];
    hsvca_pkg::t_dl           n_ls [hsvca_pkg::QW];
    hsvca_pkg::t_dl           n_lh [hsvca_pkg::QW];

    always_comb begin
        n_ls[0] = hsvca_pkg::div_step(i_ls, hsvca_pkg::QW - 1);
        n_lh[0] = hsvca_pkg::div_step(i_lh, hsvca_pkg::QW - 1);
        for (int k = 1; k < hsvca_pkg::QW; k++) begin
            n_ls[k] = hsvca_pkg::div_step(r_ls[k-1], hsvca_pkg::QW - 1 - k);
            n_lh[k] = hsvca_pkg::div_step(r_lh[k-1], hsvca_pkg::QW - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[hsvca_pkg::QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int k = 0; k < hsvca_pkg::QW; k++) begin
                r_ls[k] <= n_ls[k];
                r_lh[k] <= n_lh[k];
            end
            for (int k = 1; k < hsvca_pkg::QW; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_valid = r_vld[hsvca_pkg::QW-1];
    assign o_side  = r_sd[hsvca_pkg::QW-1];
    assign o_qs    = hsvca_pkg::CB'(r_ls[hsvca_pkg::QW-1].quo);
    assign o_qh    = 9'(r_lh[hsvca_pkg::QW-1].quo);

endmodule

@@ rtl/hsvca_back.sv @@
// Hue assembly, offsets with wrap and clamp, and HSV to RGB conversion.
module hsvca_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  hsvca_pkg::t_side         i_side,
    input  logic [hsvca_pkg::CB-1:0] i_qs,
    input  logic [8:0]               i_qh,
    input  hsvca_pkg::t_adj          i_adj,
    output logic                     o_valid,
    output hsvca_pkg::t_side         o_side,
    output logic [hsvca_pkg::CB-1:0] o_nr,
    output logic [hsvca_pkg::CB-1:0] o_ng,
    output logic [hsvca_pkg::CB-1:0] o_nb
);

    localparam int PW = 2 * hsvca_pkg::CB;
    localparam int FW = hsvca_pkg::CB + 8;
    localparam int TW = hsvca_pkg::CB + 9;

    logic [4:0]               r_vld;
    hsvca_pkg::t_side         r_sd1, r_sd2, r_sd3, r_sd4, r_sd5;

    logic [hsvca_pkg::HW-1:0] r_h1, r_h2;
    logic [hsvca_pkg::CB-1:0] r_s1, r_s2, r_v2, r_v3, r_v4;
    logic [PW-1:0]            r_pv;
    logic [FW-1:0]            r_sf;
    logic [TW-1:0]            r_st;
    logic                     r_sz3, r_sz4;
    logic [2:0]               r_sec3, r_sec4;
    logic [hsvca_pkg::DY-1:0] r_pn, r_yq, r_yt;
    logic [hsvca_pkg::CB-1:0] r_nr, r_ng, r_nb;

    int                       hp, hsum, ss, vs;
    logic [hsvca_pkg::HW-1:0] n_h2;
    logic [hsvca_pkg::CB-1:0] n_s2, n_v2, n_cs;
    logic [7:0]               fr;
    logic [hsvca_pkg::XW-1:0] xq, xt;
    logic [hsvca_pkg::CB-1:0] p, q, t, n_nr, n_ng, n_nb;

    always_comb begin
        unique case (i_side.mc)
            hsvca_pkg::MAX_GREEN: hp = 2 * hsvca_pkg::HUE_SEXT;
            hsvca_pkg::MAX_BLUE:  hp = 4 * hsvca_pkg::HUE_SEXT;
            default:              hp = 0;
        endcase
        if (i_side.neg) hp = hp - int'(i_qh);
        else            hp = hp + int'(i_qh);
        if (i_side.wrap) hp = hp + hsvca_pkg::HUE_TURN;
        if (i_side.dz)   hp = 0;
    end

    always_comb begin
        hsum = int'(r_h1) + int'(i_adj.hue) + 2 * hsvca_pkg::HUE_TURN;
        priority if (hsum >= 4 * hsvca_pkg::HUE_TURN) hsum = hsum - 4 * hsvca_pkg::HUE_TURN;
        else if (hsum >= 3 * hsvca_pkg::HUE_TURN)     hsum = hsum - 3 * hsvca_pkg::HUE_TURN;
        else if (hsum >= 2 * hsvca_pkg::HUE_TURN)     hsum = hsum - 2 * hsvca_pkg::HUE_TURN;
        else if (hsum >= hsvca_pkg::HUE_TURN)         hsum = hsum - hsvca_pkg::HUE_TURN;
        else                                          hsum = hsum;
        n_h2 = hsvca_pkg::HW'(hsum);

        ss = int'(r_s1) + int'(i_adj.sat);
        if (ss < 0) ss = 0;
        if (ss > hsvca_pkg::CMAX) ss = hsvca_pkg::CMAX;
        n_s2 = hsvca_pkg::CB'(ss);

        vs = int'(r_sd1.v) + int'(i_adj.val);
        if (vs < 0) vs = 0;
        if (vs > hsvca_pkg::CMAX) vs = hsvca_pkg::CMAX;
        n_v2 = hsvca_pkg::CB'(vs);
    end

    always_comb begin
        fr   = r_h2[7:0];
        n_cs = hsvca_pkg::CB'(hsvca_pkg::CMAX) - r_s2;
        xq   = hsvca_pkg::XW'(r_v3) * hsvca_pkg::XW'(FW'(hsvca_pkg::FULL) - r_sf);
        xt   = hsvca_pkg::XW'(r_v3) * hsvca_pkg::XW'(TW'(hsvca_pkg::FULL) - r_st);
    end

    always_comb begin
        p = hsvca_pkg::div_cmax(r_pn);
        q = hsvca_pkg::div_cmax(r_yq);
        t = hsvca_pkg::div_cmax(r_yt);
        unique case (r_sec4)
            3'd0:    begin n_nr = r_v4; n_ng = t;    n_nb = p;    end
            3'd1:    begin n_nr = q;    n_ng = r_v4; n_nb = p;    end
            3'd2:    begin n_nr = p;    n_ng = r_v4; n_nb = t;    end
            3'd3:    begin n_nr = p;    n_ng = q;    n_nb = r_v4; end
            3'd4:    begin n_nr = t;    n_ng = p;    n_nb = r_v4; end
            default: begin n_nr = r_v4; n_ng = p;    n_nb = q;    end
        endcase
        if (r_sz4) begin
            n_nr = r_v4;
            n_ng = r_v4;
            n_nb = r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd1  <= i_side;
            r_h1   <= hsvca_pkg::HW'(hp);
            r_s1   <= i_side.dz ? '0 : i_qs;

            r_sd2  <= r_sd1;
            r_h2   <= n_h2;
            r_s2   <= n_s2;
            r_v2   <= n_v2;

            r_sd3  <= r_sd2;
            r_pv   <= PW'(r_v2) * PW'(n_cs);
            r_sf   <= FW'(r_s2) * FW'(fr);
            r_st   <= TW'(r_s2) * (TW'(hsvca_pkg::HUE_SEXT) - TW'(fr));
            r_sz3  <= r_s2 == '0;
            r_sec3 <= r_h2[10:8];
            r_v3   <= r_v2;

            r_sd4  <= r_sd3;
            r_pn   <= hsvca_pkg::DY'(r_pv) + hsvca_pkg::DY'(hsvca_pkg::CMAX / 2);
            r_yq   <= hsvca_pkg::DY'((xq + hsvca_pkg::XW'(hsvca_pkg::FULL / 2)) >> 8);
            r_yt   <= hsvca_pkg::DY'((xt + hsvca_pkg::XW'(hsvca_pkg::FULL / 2)) >> 8);
            r_sz4  <= r_sz3;
            r_sec4 <= r_sec3;
            r_v4   <= r_v3;

            r_sd5  <= r_sd4;
            r_nr   <= n_nr;
            r_ng   <= n_ng;
            r_nb   <= n_nb;
        end
    end

    assign o_valid = r_vld[4];
    assign o_side  = r_sd5;
    assign o_nr    = r_nr;
    assign o_ng    = r_ng;
    assign o_nb    = r_nb;

endmodule

@@ rtl/hsvca_blend.sv @@
// Weighted blend of the adjusted pixel with the original, and output register.
module hsvca_blend (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  hsvca_pkg::t_side         i_side,
    input  logic [hsvca_pkg::CB-1:0] i_nr,
    input  logic [hsvca_pkg::CB-1:0] i_ng,
    input  logic [hsvca_pkg::CB-1:0] i_nb,
    output logic                     o_valid,
    output logic [hsvca_pkg::CB-1:0] o_red,
    output logic [hsvca_pkg::CB-1:0] o_green,
    output logic [hsvca_pkg::CB-1:0] o_blue
);

    logic                     r_v1, r_v2;
    logic [hsvca_pkg::BY-1:0] r_ar, r_ag, r_ab;
    logic [hsvca_pkg::CB-1:0] r_or, r_og, r_ob;
    logic [hsvca_pkg::BY-1:0] wi, wn;

    always_comb begin
        wn = hsvca_pkg::BY'(i_side.w);
        wi = hsvca_pkg::BY'(hsvca_pkg::WMAX) - wn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ar <= hsvca_pkg::BY'(i_side.r) * wi + hsvca_pkg::BY'(i_nr) * wn
                  + hsvca_pkg::BY'(hsvca_pkg::WMAX / 2);
            r_ag <= hsvca_pkg::BY'(i_side.g) * wi + hsvca_pkg::BY'(i_ng) * wn
                  + hsvca_pkg::BY'(hsvca_pkg::WMAX / 2);
            r_ab <= hsvca_pkg::BY'(i_side.b) * wi + hsvca_pkg::BY'(i_nb) * wn
                  + hsvca_pkg::BY'(hsvca_pkg::WMAX / 2);
            r_or <= hsvca_pkg::div_w(r_ar);
            r_og <= hsvca_pkg::div_w(r_ag);
            r_ob <= hsvca_pkg::div_w(r_ab);
        end
    end

    assign o_valid = r_v2;
    assign o_red   = r_or;
    assign o_green = r_og;
    assign o_blue  = r_ob;

endmodule

@@ rtl/hsv_color_adjust.sv @@
// Top level of the HSV color adjust pipeline: configuration registers and stage chain.
//
// Takes one pixel per clock and returns one adjusted pixel per clock while the output
// is not stalled, in order. The chain has 2 front stages, one stage per quotient bit in
// the 9-bit saturation/hue divider, 5 conversion stages and 2 blend stages. The
// divider resolves one quotient bit per stage. The whole chain holds while the output
// beat is stalled; no beat is lost or repeated.
// Write configuration only while no beat is in flight.
module hsv_color_adjust (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hsvca_pkg::CB-1:0]      i_red_in,
    input  logic [hsvca_pkg::CB-1:0]      i_green_in,
    input  logic [hsvca_pkg::CB-1:0]      i_blue_in,
    input  logic [7:0]                    i_select_weight,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hsvca_pkg::CB-1:0]      o_red_out,
    output logic [hsvca_pkg::CB-1:0]      o_green_out,
    output logic [hsvca_pkg::CB-1:0]      o_blue_out,
    input  logic                          i_cfg_we,
    input  logic [hsvca_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [hsvca_pkg::CFG_W-1:0]   i_cfg_data
);

    hsvca_pkg::t_adj          r_adj;
    logic                     r_sel;
    logic                     en;

    logic                     f_valid, d_valid, b_valid;
    hsvca_pkg::t_side         f_side, d_side, b_side;
    hsvca_pkg::t_dl           f_ls, f_lh;
    logic [hsvca_pkg::CB-1:0] d_qs;
    logic [8:0]               d_qh;
    logic [hsvca_pkg::CB-1:0] b_nr, b_ng, b_nb;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj <= '0;
            r_sel <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (hsvca_pkg::t_cfg'(i_cfg_idx))
                hsvca_pkg::CFG_HUE: r_adj.hue <= i_cfg_data[11:0];
                hsvca_pkg::CFG_SAT: r_adj.sat <= i_cfg_data[8:0];
                hsvca_pkg::CFG_VAL: r_adj.val <= i_cfg_data[8:0];
                hsvca_pkg::CFG_SEL: r_sel     <= i_cfg_data[0];
                default:            r_sel     <= r_sel;
            endcase
        end
    end

    hsvca_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_red    (i_red_in),
        .i_green  (i_green_in),
        .i_blue   (i_blue_in),
        .i_weight (i_select_weight),
        .i_sel    (r_sel),
        .o_valid  (f_valid),
        .o_side   (f_side),
        .o_ls     (f_ls),
        .o_lh     (f_lh)
    );

    hsvca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_ls    (f_ls),
        .i_lh    (f_lh),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_qs    (d_qs),
        .o_qh    (d_qh)
    );

    hsvca_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_side  (d_side),
        .i_qs    (d_qs),
        .i_qh    (d_qh),
        .i_adj   (r_adj),
        .o_valid (b_valid),
        .o_side  (b_side),
        .o_nr    (b_nr),
        .o_ng    (b_ng),
        .o_nb    (b_nb)
    );

    hsvca_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (b_valid),
        .i_side  (b_side),
        .i_nr    (b_nr),
        .i_ng    (b_ng),
        .i_nb    (b_nb),
        .o_valid (o_valid),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

endmodule

@@ sim/hsv_color_adjust_tb.sv @@
// Self-checking testbench for the HSV color adjust pipeline: directed table, random pixels, stalls.
module hsv_color_adjust_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [hsvca_pkg::CB-1:0]     i_red_in = '0;
    logic [hsvca_pkg::CB-1:0]     i_green_in = '0;
    logic [hsvca_pkg::CB-1:0]     i_blue_in = '0;
    logic [7:0]                   i_select_weight = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [hsvca_pkg::CB-1:0]     o_red_out;
    logic [hsvca_pkg::CB-1:0]     o_green_out;
    logic [hsvca_pkg::CB-1:0]     o_blue_out;
    logic                         i_cfg_we = 1'b0;
    logic [hsvca_pkg::CFG_IW-1:0] i_cfg_idx = '0;
    logic [hsvca_pkg::CFG_W-1:0]  i_cfg_data = '0;

    typedef struct packed {
        logic [hsvca_pkg::CB-1:0] r;
        logic [hsvca_pkg::CB-1:0] g;
        logic [hsvca_pkg::CB-1:0] b;
    } t_pix;

    typedef struct {
        t_pix pin;
        logic [7:0] w;
        bit   known;
        t_pix pout;
    } t_row;

    int   hue_sh;
    int   sat_off;
    int   val_off;
    bit   sel_on;
    t_pix adjusted_q[$];
    int   errors = 0;
    int   src_idle = 0;
    int   snk_idle = 0;
    bit   hold_off = 1'b0;

    hsv_color_adjust dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int rnd_div(longint n, longint d);
        return int'((n + d / 2) / d);
    endfunction

    function automatic int hue_part(int d, int den);
        int m;
        m = d < 0 ? -d : d;
        m = (m * hsvca_pkg::HUE_SEXT + den / 2) / den;
        return d < 0 ? -m : m;
    endfunction

    function automatic int clip(int x);
        return x < 0 ? 0 : (x > hsvca_pkg::CMAX ? hsvca_pkg::CMAX : x);
    endfunction

    function automatic int mix(int o, int a, int w);
        return (o * (255 - w) + a * w + 127) / 255;
    endfunction

    function automatic t_pix adjust_pixel(t_pix px, logic [7:0] wi);
        int r, g, b, w, mx, mn, dl, v, s, h, f, p, q, t, nr, ng, nb;
        t_pix o;
        r = px.r; g = px.g; b = px.b;
        w = sel_on ? int'(wi) : 255;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        v = mx;
        s = mx > 0 ? rnd_div(dl * hsvca_pkg::CMAX, mx) : 0;
        h = 0;
        if (dl > 0) begin
            if (mx == r) h = hue_part(g - b, dl) + (g < b ? hsvca_pkg::HUE_TURN : 0);
            else if (mx == g) h = 2 * hsvca_pkg::HUE_SEXT + hue_part(b - r, dl);
            else h = 4 * hsvca_pkg::HUE_SEXT + hue_part(r - g, dl);
        end
        h = (h + hue_sh) % hsvca_pkg::HUE_TURN;
        if (h < 0) h += hsvca_pkg::HUE_TURN;
        s = clip(s + sat_off);
        v = clip(v + val_off);
        if (s == 0) begin
            nr = v; ng = v; nb = v;
        end else begin
            f = h % hsvca_pkg::HUE_SEXT;
            p = rnd_div(v * (hsvca_pkg::CMAX - s), hsvca_pkg::CMAX);
            q = rnd_div(longint'(v) * (hsvca_pkg::FULL - s * f), hsvca_pkg::FULL);
            t = rnd_div(longint'(v) * (hsvca_pkg::FULL - s * (hsvca_pkg::HUE_SEXT - f)),
                        hsvca_pkg::FULL);
            case (h / hsvca_pkg::HUE_SEXT)
                0: begin nr = v; ng = t; nb = p; end
                1: begin nr = q; ng = v; nb = p; end
                2: begin nr = p; ng = v; nb = t; end
                3: begin nr = p; ng = q; nb = v; end
                4: begin nr = t; ng = p; nb = v; end
                default: begin nr = v; ng = p; nb = q; end
            endcase
        end
        o.r = hsvca_pkg::CB'(mix(r, nr, w));
        o.g = hsvca_pkg::CB'(mix(g, ng, w));
        o.b = hsvca_pkg::CB'(mix(b, nb, w));
        return o;
    endfunction

    task automatic write_reg(hsvca_pkg::t_cfg idx, int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= hsvca_pkg::CFG_W'(val);
        case (idx)
            hsvca_pkg::CFG_HUE: hue_sh = int'($signed(hsvca_pkg::CFG_W'(val)));
            hsvca_pkg::CFG_SAT: sat_off = int'($signed(9'(val)));
            hsvca_pkg::CFG_VAL: val_off = int'($signed(9'(val)));
            default: sel_on = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int h, int s, int v, int sel);
        write_reg(hsvca_pkg::CFG_HUE, h);
        write_reg(hsvca_pkg::CFG_SAT, s);
        write_reg(hsvca_pkg::CFG_VAL, v);
        write_reg(hsvca_pkg::CFG_SEL, sel);
    endtask

    task automatic send_pixel(t_pix px, logic [7:0] w, bit known, t_pix exp_px);
        while (($urandom_range(99) < src_idle)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_red_in        <= px.r;
        i_green_in      <= px.g;
        i_blue_in       <= px.b;
        i_select_weight <= w;
        adjusted_q.push_back(known ? exp_px : adjust_pixel(px, w));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (adjusted_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic random_run(int n, int src, int snk);
        t_pix px;
        src_idle = src;
        snk_idle = snk;
        repeat (n) begin
            px = t_pix'(24'($urandom));
            if ($urandom_range(9) == 0) px.g = px.r;
            if ($urandom_range(9) == 0) px.b = px.r;
            send_pixel(px, 8'($urandom), 1'b0, '0);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < snk_idle);
        if (o_valid && !i_stall) begin
            if (adjusted_q.size() == 0) begin
                $display("%0t: unexpected beat %h %h %h", $time,
                         o_red_out, o_green_out, o_blue_out);
                errors++;
            end else begin
                if ({o_red_out, o_green_out, o_blue_out} != adjusted_q[0]) begin
                    $display("%0t: expected %h %h %h actual %h %h %h", $time,
                             adjusted_q[0].r, adjusted_q[0].g, adjusted_q[0].b,
                             o_red_out, o_green_out, o_blue_out);
                    errors++;
                end
                void'(adjusted_q.pop_front());
            end
        end
    end

    t_row rows[$];

    initial begin
        hue_sh = 0; sat_off = 0; val_off = 0; sel_on = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rows = '{
            '{'{8'h00, 8'h00, 8'h00}, 8'h00, 1, '{8'h00, 8'h00, 8'h00}},
            '{'{8'hff, 8'hff, 8'hff}, 8'h00, 1, '{8'hff, 8'hff, 8'hff}},
            '{'{8'hff, 8'h00, 8'h00}, 8'h00, 1, '{8'hff, 8'h00, 8'h00}},
            '{'{8'h00, 8'hff, 8'h00}, 8'hff, 1, '{8'h00, 8'hff, 8'h00}},
            '{'{8'h00, 8'h00, 8'hff}, 8'h5a, 1, '{8'h00, 8'h00, 8'hff}},
            '{'{8'h80, 8'h80, 8'h80}, 8'h00, 1, '{8'h80, 8'h80, 8'h80}},
            '{'{8'hff, 8'h00, 8'h80}, 8'h00, 0, '0},
            '{'{8'h12, 8'h34, 8'h56}, 8'h00, 0, '0},
            '{'{8'hc8, 8'h64, 8'h01}, 8'h00, 0, '0},
            '{'{8'h01, 8'h00, 8'h00}, 8'h00, 0, '0}
        };
        foreach (rows[i]) send_pixel(rows[i].pin, rows[i].w, rows[i].known, rows[i].pout);
        drain();
        set_regs(1535, 255, -255, 1);
        send_pixel('{8'hff, 8'h00, 8'h00}, 8'h00, 1, '{8'hff, 8'h00, 8'h00});
        send_pixel('{8'h30, 8'h90, 8'hf0}, 8'hff, 0, '0);
        send_pixel('{8'hf0, 8'h30, 8'h90}, 8'h80, 0, '0);
        drain();
        set_regs(-1535, -255, 255, 1);
        send_pixel('{8'hff, 8'h00, 8'h00}, 8'hff, 1, '{8'hff, 8'hff, 8'hff});
        send_pixel('{8'h00, 8'h00, 8'h00}, 8'hff, 1, '{8'hff, 8'hff, 8'hff});
        send_pixel('{8'h55, 8'haa, 8'h11}, 8'h01, 0, '0);
        drain();
        set_regs(12'h800, 0, 0, 0);
        send_pixel('{8'h40, 8'hc0, 8'h20}, 8'h00, 0, '0);
        send_pixel('{8'hff, 8'hfe, 8'h00}, 8'h00, 0, '0);
        drain();
        set_regs(12'h7ff, 9'h100, 9'h0ff, 1);
        send_pixel('{8'h9c, 8'h27, 8'he1}, 8'h77, 0, '0);
        drain();
        set_regs(256, 40, -20, 0);
        random_run(400, 0, 0);
        set_regs(int'($urandom), int'($urandom), int'($urandom), 1);
        random_run(350, 79, 0);
        set_regs(-700, -100, 60, 1);
        random_run(350, 0, 79);
        set_regs(int'($urandom), int'($urandom), int'($urandom), 1);
        random_run(350, 12, 12);
        set_regs(900, 255, 255, 0);
        fork
            random_run(150, 0, 0);
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

@@ hsv_color_adjust.f @@
rtl/hsvca_pkg.sv
rtl/hsvca_front.sv
rtl/hsvca_div.sv
rtl/hsvca_back.sv
rtl/hsvca_blend.sv
rtl/hsv_color_adjust.sv
sim/hsv_color_adjust_tb.sv
